// File: design/sarp_pkg.sv
// Shared types and constants for the shelf atlas rectangle packer.
// Used by sarp_cell and shelf_atlas_rect_packer_top; depends on nothing.
`default_nettype none
package sarp_pkg;

    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int PAGE_W  = 3;
    localparam int SUM_W   = DIM_W + 1;

    localparam logic [DIM_W-1:0] DIM_LIMIT   = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_RESET   = 13'd256;

    localparam logic CFG_PAGE_WIDTH  = 1'b0;
    localparam logic CFG_PAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic              vld;
        logic              done;
        logic              placed;
        logic [PAGE_W-1:0] page;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } t_tok;

endpackage
`default_nettype wire

// File: design/shelf_atlas_rect_packer_top.sv
// Top level of the shelf atlas rectangle packer: config registers, request check,
// the row of page cells, result hold and output register; uses sarp_pkg and sarp_cell.
//
// Each request walks a row of MAX_PAGES page cells, one cell per cycle; a page not yet
// opened holds an empty shelf and opens when the walk reaches it, so the first free page
// takes whatever no open page fits. A result passes from the input token register through
// the cell row into the result hold register and then to the output register. One item is
// in the row at a time; the next is taken as soon as the previous result has moved to the
// output register, even while that result still waits to be taken. Zero or oversized
// rectangles and a full page table return placed = 0 with zero page and position.
`default_nettype none
module shelf_atlas_rect_packer_top
    import sarp_pkg::*;
#(
    parameter int MAX_PAGES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // req_width[12:0], req_height[25:13], zero fill
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // page_index[2:0], pos_x[14:3], pos_y[26:15], zero fill
    output logic             o_m_tuser    // placed
);

    logic [DIM_W-1:0] r_pw_cfg, r_ph_cfg;
    logic [DIM_W-1:0] w_pw, w_ph;
    logic [DIM_W-1:0] w_rw, w_rh;
    logic             w_acc, w_reject, w_move;
    logic             r_busy;
    t_tok             r_in_tok, n_in_tok;
    t_tok             w_tok [MAX_PAGES+1];
    logic [MAX_PAGES:0] w_tok_vld;
    logic             r_res_vld;
    t_tok             r_res;
    logic             r_out_vld;
    logic [31:0]      r_out_data;
    logic             r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_cfg <= DIM_RESET;
            r_ph_cfg <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGE_WIDTH:  r_pw_cfg <= i_cfg_data;
                CFG_PAGE_HEIGHT: r_ph_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pw = (r_pw_cfg > DIM_LIMIT) ? DIM_LIMIT : r_pw_cfg;
    assign w_ph = (r_ph_cfg > DIM_LIMIT) ? DIM_LIMIT : r_ph_cfg;

    assign w_rw       = i_s_tdata[12:0];
    assign w_rh       = i_s_tdata[25:13];
    assign o_s_tready = !r_busy;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_reject   = (w_rw == '0) || (w_rh == '0) || (w_rw > w_pw) || (w_rh > w_ph);

    always_comb begin
        n_in_tok      = '0;
        n_in_tok.vld  = w_acc;
        n_in_tok.done = w_reject;
        n_in_tok.w    = w_rw;
        n_in_tok.h    = w_rh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok <= '0;
        end else begin
            r_in_tok <= n_in_tok;
        end
    end

    assign w_tok[0] = r_in_tok;

    for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
        sarp_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pw    (w_pw),
            .i_ph    (w_ph),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    for (genvar k = 0; k <= MAX_PAGES; k++) begin : g_vld
        assign w_tok_vld[k] = w_tok[k].vld;
    end

    assign w_move = r_res_vld && (!r_out_vld || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_tok[MAX_PAGES].vld) begin
                r_res_vld <= 1'b1;
            end else if (w_move) begin
                r_res_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[MAX_PAGES].vld) begin
            r_res <= w_tok[MAX_PAGES];
        end
        if (w_move) begin
            r_out_data <= {5'd0, r_res.y, r_res.x, r_res.page};
            r_out_user <= r_res.placed;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_vld) <= 1)
        else $error("more than one item in the cell row");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld || (|w_tok_vld)) |-> r_busy)
        else $error("item in flight while not busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy && r_in_tok.vld)
        else $error("accepted item did not enter the row");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("failed result carries nonzero position");

endmodule
`default_nettype wire

// File: design/sarp_cell.sv
// One page of the atlas: cursor x, shelf top y and shelf height.
// Tries the passing request token and registers it to the next cell; uses sarp_pkg.
`default_nettype none
module sarp_cell
    import sarp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DIM_W-1:0] i_pw,
    input  wire logic [DIM_W-1:0] i_ph,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok
);

    logic [DIM_W-1:0] r_x, r_y, r_rh;
    logic [DIM_W-1:0] n_x, n_y, n_rh;
    t_tok             r_tok, n_tok;

    logic [SUM_W-1:0] w_xw, w_ny, w_nyh;
    logic [DIM_W-1:0] w_nx, w_nrh;
    logic             w_wrap, w_fit;

    always_comb begin
        w_xw   = {1'b0, r_x} + {1'b0, i_tok.w};
        w_wrap = w_xw > {1'b0, i_pw};
        w_ny   = w_wrap ? ({1'b0, r_y} + {1'b0, r_rh}) : {1'b0, r_y};
        w_nx   = w_wrap ? '0 : r_x;
        w_nrh  = w_wrap ? '0 : r_rh;
        w_nyh  = w_ny + {1'b0, i_tok.h};
        w_fit  = w_nyh <= {1'b0, i_ph};

        n_x   = r_x;
        n_y   = r_y;
        n_rh  = r_rh;
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.done && w_fit) begin
            n_x          = w_nx + i_tok.w;
            n_y          = w_ny[DIM_W-1:0];
            n_rh         = (i_tok.h > w_nrh) ? i_tok.h : w_nrh;
            n_tok.done   = 1'b1;
            n_tok.placed = 1'b1;
            n_tok.page   = PAGE_W'(IDX);
            n_tok.x      = w_nx[POS_W-1:0];
            n_tok.y      = w_ny[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_rh    <= '0;
            r_tok   <= '0;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_rh    <= n_rh;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for shelf_atlas_rect_packer_top: streams rectangle requests through
// several page-size settings and idle patterns and checks every placement against a shelf model.
// Depends on sarp_pkg and the packer RTL only.
module testbench;
    import sarp_pkg::*;

    localparam int PAGES = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_PHASES = 9;

    typedef struct packed {
        logic              placed;
        logic [PAGE_W-1:0] page;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } t_placement;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_PAGE_WIDTH;
    logic [12:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    shelf_atlas_rect_packer_top #(.MAX_PAGES(PAGES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // rectangle requests waiting to be sent: {height, width}
    logic [2*DIM_W-1:0] pending_rects[$];
    t_placement         expected_placements[$];
    bit                 offered = 1'b0;
    int unsigned        src_idle_pct = 0;
    int unsigned        sink_stall_pct = 0;
    int unsigned        errors = 0;
    int unsigned        cycles = 0;

    // shelf model state
    logic [DIM_W-1:0] page_w_reg = DIM_RESET;
    logic [DIM_W-1:0] page_h_reg = DIM_RESET;
    int unsigned      open_cnt = 1;
    logic [DIM_W-1:0] col_pos[PAGES];
    logic [DIM_W-1:0] top_y[PAGES];
    logic [DIM_W-1:0] row_h[PAGES];

    initial begin
        for (int p = 0; p < PAGES; p++) begin
            col_pos[p] = '0;
            top_y[p] = '0;
            row_h[p] = '0;
        end
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        return (v > DIM_LIMIT) ? int'(DIM_LIMIT) : int'(v);
    endfunction

    function automatic t_placement place_rect(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        t_placement  res;
        int unsigned pw;
        int unsigned ph;
        int unsigned x;
        int unsigned y;
        int unsigned rh;
        pw = clamp_dim(page_w_reg);
        ph = clamp_dim(page_h_reg);
        res = '0;
        if (w == 0 || h == 0 || w > pw || h > ph)
            return res;
        for (int p = 0; p < open_cnt; p++) begin
            x = col_pos[p];
            y = top_y[p];
            rh = row_h[p];
            if (x + w > pw) begin
                y = y + rh;
                x = 0;
                rh = 0;
            end
            if (y + h <= ph) begin
                col_pos[p] = DIM_W'(x + w);
                top_y[p] = DIM_W'(y);
                row_h[p] = (h > rh) ? h : DIM_W'(rh);
                res.placed = 1'b1;
                res.page = PAGE_W'(p);
                res.x = POS_W'(x);
                res.y = POS_W'(y);
                return res;
            end
        end
        if (open_cnt >= PAGES)
            return res;
        col_pos[open_cnt] = w;
        top_y[open_cnt] = '0;
        row_h[open_cnt] = h;
        res.placed = 1'b1;
        res.page = PAGE_W'(open_cnt);
        open_cnt++;
        return res;
    endfunction

    function automatic logic [2*DIM_W-1:0] rand_rect(int unsigned pw, int unsigned ph);
        int unsigned      sel;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        sel = $urandom_range(99);
        if (sel < 68) begin
            w = DIM_W'($urandom_range(1, (pw / 6 > 1) ? pw / 6 : 1));
            h = DIM_W'($urandom_range(1, (ph / 6 > 1) ? ph / 6 : 1));
        end else if (sel < 78) begin
            w = DIM_W'($urandom_range(pw / 2, pw));
            h = DIM_W'($urandom_range(1, (ph / 3 > 1) ? ph / 3 : 1));
        end else if (sel < 86) begin
            w = $urandom_range(1) ? DIM_W'(pw) : 13'd1;
            h = $urandom_range(1) ? DIM_W'(ph) : DIM_W'($urandom_range(1, ph));
        end else if (sel < 94) begin
            w = DIM_W'($urandom_range(8191));
            h = DIM_W'($urandom_range(8191));
        end else begin
            w = $urandom_range(1) ? 13'd0 : 13'($urandom_range(1, pw));
            h = (w == 0) ? 13'($urandom_range(8191)) : 13'd0;
        end
        return {h, w};
    endfunction

    task automatic write_page_dim(logic idx, logic [DIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGE_WIDTH)
            page_w_reg = value;
        else
            page_h_reg = value;
    endtask

    task automatic wait_idle();
        while (pending_rects.size() != 0 || offered || expected_placements.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && !offered) begin
            if (pending_rects.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {6'd0, pending_rects[0]};
                offered = 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready && offered) begin
            expected_placements.push_back(place_rect(i_s_tdata[12:0], i_s_tdata[25:13]));
            void'(pending_rects.pop_front());
            offered = 1'b0;
        end
    end

    // result monitor
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_placements.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h/%b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = expected_placements.pop_front();
                check_field("placed", want.placed, o_m_tuser);
                check_field("page_index", want.page, o_m_tdata[2:0]);
                check_field("pos_x", want.x, o_m_tdata[14:3]);
                check_field("pos_y", want.y, o_m_tdata[26:15]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned phase_pw[N_PHASES] = '{64, 300, 1024, 4096, 8191, 40, 2048, 5000, 4096};
        int unsigned phase_ph[N_PHASES] = '{64, 128, 700, 4096, 5000, 17, 4096, 64, 8191};
        int unsigned phase_n[N_PHASES] = '{150, 200, 200, 250, 250, 150, 250, 150, 150};
        int unsigned src_pct[4] = '{0, 81, 0, 24};
        int unsigned sink_pct[4] = '{0, 0, 81, 24};
        logic [DIM_W-1:0] dir_w[20] = '{0, 5, 0, 257, 10, 8191, 256, 1, 255, 10,
                                        5, 300, 4096, 200, 200, 200, 200, 200, 200, 200};
        logic [DIM_W-1:0] dir_h[20] = '{5, 0, 0, 10, 257, 8191, 256, 1, 1, 20,
                                        5, 1, 1, 200, 200, 200, 200, 200, 200, 200};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_page_dim(CFG_PAGE_WIDTH, 13'd256);
        write_page_dim(CFG_PAGE_HEIGHT, 13'd256);
        for (int i = 0; i < 20; i++)
            pending_rects.push_back({dir_h[i], dir_w[i]});
        for (int i = 0; i < 3; i++)
            pending_rects.push_back({13'd256, 13'd256});
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_page_dim(CFG_PAGE_WIDTH, DIM_W'(phase_pw[ph]));
            write_page_dim(CFG_PAGE_HEIGHT, DIM_W'(phase_ph[ph]));
            src_idle_pct = src_pct[ph % 4];
            sink_stall_pct = sink_pct[ph % 4];
            for (int i = 0; i < phase_n[ph]; i++)
                pending_rects.push_back(rand_rect(clamp_dim(DIM_W'(phase_pw[ph])),
                                                  clamp_dim(DIM_W'(phase_ph[ph]))));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_placements.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: filelist.f
design/sarp_pkg.sv
design/sarp_cell.sv
design/shelf_atlas_rect_packer_top.sv
tb/sv/testbench.sv
